### rtl/dfs_pkg.sv
// shared types and constants for the depth-first search block
`timescale 1ns / 1ps

package dfs_pkg;

    // graph size limits
    localparam int MAX_VERTICES = 32;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = VIDX_W + 1;

    // input item kinds
    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    // one input word
    typedef struct packed {
        t_op                       op;
        logic [VIDX_W-1:0]         row_index;
        logic [MAX_VERTICES-1:0]   row_bits;
        logic [VIDX_W-1:0]         start_vertex;
    } t_item;

    // one result word
    typedef struct packed {
        logic [VIDX_W-1:0] vertex;
        logic [VIDX_W-1:0] parent;
        logic              reached;
        logic              last;
    } t_result;

endpackage

### rtl/dfs_parent_tree_adjacency_matrix.sv
// Depth-first search over an adjacency matrix, reporting each vertex's tree parent.
//
// Input stream (s_axis): tuser selects the word kind, 0 loads one adjacency
// row, 1 starts a search. tdata carries row_index, row_bits and start_vertex.
// Output stream (m_axis): one word per vertex 0 .. n-1 in ascending order with
// vertex, parent and reached flag; tlast marks vertex n-1.
// n is the configuration register num_vertices clamped into 1 .. 32. The user
// must see that it is written through i_cfg_we / i_cfg_wdata while the block
// is idle; the block has no check for it. A load word keeps the block idle.
// A search pops stack entries, each followed by a scan of its stored row with
// one neighbour checked per cycle, then sees the empty stack and hands out the
// results (at once if the start vertex is n or above); the input is not ready meanwhile.
// Results go through one output register: a stalled receiver holds the
// search in its reporting phase, nothing is dropped.
// Synchronous active-low reset returns to idle, empties the stack, clears
// the visited and reached flags and sets num_vertices to 32; adjacency rows
// are not cleared and must be loaded before a search reads them.
`timescale 1ns / 1ps

module dfs_parent_tree_adjacency_matrix
    import dfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,      // num_vertices
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,     // row_index[4:0], row_bits[36:5], start_vertex[41:37]
    input  logic        s_axis_tuser,     // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,     // vertex[4:0], parent[9:5], reached[10]
    output logic        m_axis_tlast
);

    logic [5:0]       r_num_vertices;
    logic [CNT_W-1:0] num;
    t_item            item;
    t_result          res;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vertices <= 6'd32;
        end else if (i_cfg_we) begin
            r_num_vertices <= i_cfg_wdata;
        end
    end

    // clamp vertex count into the supported range
    always_comb begin
        priority if (r_num_vertices == '0) begin
            num = CNT_W'(1);
        end else if (CNT_W'(r_num_vertices) > CNT_W'(MAX_VERTICES)) begin
            num = CNT_W'(MAX_VERTICES);
        end else begin
            num = CNT_W'(r_num_vertices);
        end
    end

    // unpack the input word
    assign item.op           = t_op'(s_axis_tuser);
    assign item.row_index    = s_axis_tdata[4:0];
    assign item.row_bits     = s_axis_tdata[36:5];
    assign item.start_vertex = s_axis_tdata[41:37];

    dfs_search u_search (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (s_axis_tvalid),
        .o_item_ready (s_axis_tready),
        .i_num        (num),
        .o_res        (res),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready)
    );

    // pack the result word
    assign m_axis_tdata = {5'd0, res.reached, res.parent, res.vertex};
    assign m_axis_tlast = res.last;

endmodule

### rtl/dfs_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module dfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/dfs_search.sv
// search sequencer: row store, stack, visited and parent stores, result register
`timescale 1ns / 1ps

module dfs_search
    import dfs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_item            i_item,
    input  logic             i_item_valid,
    output logic             o_item_ready,
    input  logic [CNT_W-1:0] i_num,
    output t_result          o_res,
    output logic             o_res_valid,
    input  logic             i_res_ready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_count;
    logic [VIDX_W-1:0]       r_v;
    logic [VIDX_W-1:0]       r_w;
    logic [VIDX_W-1:0]       r_k;
    logic [MAX_VERTICES-1:0] r_visited;
    logic [MAX_VERTICES-1:0] r_reached;
    logic [VIDX_W-1:0]       r_parent [MAX_VERTICES];
    logic [VIDX_W-1:0]       r_stack  [MAX_VERTICES];
    t_result                 r_res;
    logic                    r_res_valid;

    logic                    accept;
    logic                    ram_we;
    logic                    ram_re;
    logic [VIDX_W-1:0]       ram_raddr;
    logic [MAX_VERTICES-1:0] row;
    logic [VIDX_W-1:0]       last_idx;
    logic [VIDX_W-1:0]       top_idx;
    logic                    out_free;
    logic                    emit_fire;
    logic                    hit;

    assign o_item_ready = (r_state == S_IDLE);
    assign accept       = i_item_valid && o_item_ready;
    assign last_idx     = VIDX_W'(i_num - CNT_W'(1));
    assign top_idx      = VIDX_W'(r_count - CNT_W'(1));
    assign out_free     = !r_res_valid || i_res_ready;
    assign emit_fire    = (r_state == S_EMIT) && out_free;
    assign hit          = row[r_w] && !r_visited[r_w];

    // adjacency row store is read once per pop
    assign ram_we    = accept && (i_item.op == OP_LOAD);
    assign ram_re    = (r_state == S_POP) && (r_count != '0);
    assign ram_raddr = r_stack[top_idx];

    dfs_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_item.row_index),
        .i_wdata (i_item.row_bits),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (row)
    );

    // sequencer: pop, scan neighbours one per cycle, then report each vertex
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_visited   <= '0;
            r_reached   <= '0;
            r_res_valid <= 1'b0;
            r_w         <= '0;
            r_k         <= '0;
        end else begin
            // result register empties when taken and nothing new goes in
            if (r_res_valid && i_res_ready && !emit_fire) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_item.op == OP_SEARCH)) begin
                        r_visited <= '0;
                        r_k       <= '0;
                        if (CNT_W'(i_item.start_vertex) < i_num) begin
                            r_stack[0]                     <= i_item.start_vertex;
                            r_count                        <= CNT_W'(1);
                            r_parent[i_item.start_vertex]  <= i_item.start_vertex;
                            r_reached <= MAX_VERTICES'(1) << i_item.start_vertex;
                            r_state                        <= S_POP;
                        end else begin
                            r_count   <= '0;
                            r_reached <= '0;
                            r_state   <= S_EMIT;
                        end
                    end
                end
                S_POP: begin
                    if (r_count == '0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_count              <= r_count - CNT_W'(1);
                        r_v                  <= r_stack[top_idx];
                        r_visited[r_stack[top_idx]] <= 1'b1;
                        r_w                  <= '0;
                        r_state              <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_parent[r_w]  <= r_v;
                        r_reached[r_w] <= 1'b1;
                        if (r_count < i_num) begin
                            r_stack[r_count[VIDX_W-1:0]] <= r_w;
                            r_count                      <= r_count + CNT_W'(1);
                        end
                    end
                    if (r_w == last_idx) begin
                        r_state <= S_POP;
                    end else begin
                        r_w <= r_w + VIDX_W'(1);
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_res.vertex  <= r_k;
                        r_res.parent  <= r_reached[r_k] ? r_parent[r_k] : '0;
                        r_res.reached <= r_reached[r_k];
                        r_res.last    <= (r_k == last_idx);
                        r_res_valid   <= 1'b1;
                        if (r_k == last_idx) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + VIDX_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

endmodule

### sim/tb_dfs_parent_tree_adjacency_matrix.sv
// testbench for the depth-first search parent tree block: directed table, then random traffic
`timescale 1ns / 1ps

module tb_dfs_parent_tree_adjacency_matrix;
    import dfs_pkg::*;

    localparam int CYCLE_LIMIT   = 20_000_000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_WORDS  = 210;
    localparam int NUM_PHASES    = 10;
    localparam int DIR_ROWS      = 23;

    // directed table rows are either a stream word or a register write
    typedef enum logic {
        ENTRY_WORD = 1'b0,
        ENTRY_CFG  = 1'b1
    } t_entry_kind;

    typedef struct packed {
        t_entry_kind             kind;
        t_op                     op;
        logic [VIDX_W-1:0]       row_index;
        logic [MAX_VERTICES-1:0] row_bits;
        logic [VIDX_W-1:0]       start_vertex;
        logic [5:0]              cfg_value;
        logic                    typed;        // expected result typed in below
        logic [MAX_VERTICES-1:0] exp_reached;  // reached flag per vertex
        logic [VIDX_W-1:0]       exp_parent;   // parent of every reached vertex
    } t_dir_entry;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [5:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;     // row_index[4:0], row_bits[36:5], start_vertex[41:37]
    logic        s_axis_tuser;     // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;     // vertex[4:0], parent[9:5], reached[10]
    logic        m_axis_tlast;

    // predictor copy of the graph and the register
    logic [MAX_VERTICES-1:0] adj_rows [MAX_VERTICES];
    logic [5:0]              cfg_num_vertices;
    t_result                 parent_reports_q [$];

    int  err_count   = 0;
    int  hold_ticket = 0;
    bit  quiet_mode  = 1'b0;
    longint cycle_count = 0;

    // hand-checked cases: reset size, one vertex, start out of range, star graphs,
    // full stack with duplicate pushes, register clamping at zero
    t_dir_entry dir_table [DIR_ROWS] = '{
        '{ENTRY_WORD, OP_LOAD,   5'd0,  32'h0000_0000, 5'd0,  6'd0,  1'b0, 32'h0, 5'd0},
        '{ENTRY_WORD, OP_SEARCH, 5'd0,  32'h0000_0000, 5'd0,  6'd0,  1'b1, 32'h1, 5'd0},
        '{ENTRY_CFG,  OP_LOAD,   5'd0,  32'h0000_0000, 5'd0,  6'd1,  1'b0, 32'h0, 5'd0},
        '{ENTRY_WORD, OP_LOAD,   5'd0,  32'hFFFF_FFFF, 5'd31, 6'd0,  1'b0, 32'h0, 5'd0},
        '{ENTRY_WORD, OP_SEARCH, 5'd0,  32'h0000_0000, 5'd0,  6'd0,  1'b1, 32'h1, 5'd0},
        '{ENTRY_WORD, OP_SEARCH, 5'd31, 32'hFFFF_FFFF, 5'd31, 6'd0,  1'b1, 32'h0, 5'd0},
        '{ENTRY_CFG,  OP_LOAD,   5'd0,  32'h0000_0000, 5'd0,  6'd4,  1'b0, 32'h0, 5'd0},
        '{ENTRY_WORD, OP_LOAD,   5'd1,  32'h0000_0000, 5'd0,  6'd0,  1'b0, 32'h0, 5'd0},
        '{ENTRY_WORD, OP_LOAD,   5'd2,  32'h0000_0000, 5'd0,  6'd0,  1'b0, 32'h0, 5'd0},
        '{ENTRY_WORD, OP_LOAD,   5'd3,  32'h0000_0000, 5'd0,  6'd0,  1'b0, 32'h0, 5'd0},
        '{ENTRY_WORD, OP_SEARCH, 5'd0,  32'h0000_0000, 5'd0,  6'd0,  1'b1, 32'hF, 5'd0},
        '{ENTRY_WORD, OP_SEARCH, 5'd0,  32'h0000_0000, 5'd2,  6'd0,  1'b1, 32'h4, 5'd2},
        '{ENTRY_WORD, OP_LOAD,   5'd31, 32'hFFFF_FFFF, 5'd31, 6'd0,  1'b0, 32'h0, 5'd0},
        '{ENTRY_WORD, OP_LOAD,   5'd0,  32'h0000_000E, 5'd0,  6'd0,  1'b0, 32'h0, 5'd0},
        '{ENTRY_WORD, OP_LOAD,   5'd3,  32'h0000_0007, 5'd0,  6'd0,  1'b0, 32'h0, 5'd0},
        '{ENTRY_WORD, OP_SEARCH, 5'd0,  32'h0000_0000, 5'd0,  6'd0,  1'b0, 32'h0, 5'd0},
        '{ENTRY_WORD, OP_SEARCH, 5'd0,  32'h0000_0000, 5'd3,  6'd0,  1'b0, 32'h0, 5'd0},
        '{ENTRY_WORD, OP_LOAD,   5'd1,  32'h0000_0009, 5'd0,  6'd0,  1'b0, 32'h0, 5'd0},
        '{ENTRY_WORD, OP_SEARCH, 5'd0,  32'h0000_0000, 5'd1,  6'd0,  1'b0, 32'h0, 5'd0},
        '{ENTRY_CFG,  OP_LOAD,   5'd0,  32'h0000_0000, 5'd0,  6'd0,  1'b0, 32'h0, 5'd0},
        '{ENTRY_WORD, OP_SEARCH, 5'd0,  32'h0000_0000, 5'd0,  6'd0,  1'b1, 32'h1, 5'd0},
        '{ENTRY_CFG,  OP_LOAD,   5'd0,  32'h0000_0000, 5'd0,  6'd2,  1'b0, 32'h0, 5'd0},
        '{ENTRY_WORD, OP_SEARCH, 5'd0,  32'h0000_0000, 5'd1,  6'd0,  1'b1, 32'h3, 5'd1}
    };

    dfs_parent_tree_adjacency_matrix i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // vertex count in use, register clamped into 1 .. MAX_VERTICES
    function automatic int active_vertices();
        if (cfg_num_vertices == 6'd0)
            return 1;
        if (cfg_num_vertices > MAX_VERTICES)
            return MAX_VERTICES;
        return int'(cfg_num_vertices);
    endfunction

    // depth-first search on the predictor's graph, queues one report per vertex
    function automatic void predict_parent_tree(input logic [VIDX_W-1:0] start);
        int                      n;
        int                      depth;
        int                      v;
        logic [MAX_VERTICES-1:0] seen;
        logic [MAX_VERTICES-1:0] got_parent;
        logic [VIDX_W-1:0]       parent_of [MAX_VERTICES];
        logic [VIDX_W-1:0]       pending [MAX_VERTICES];
        t_result                 rep;
        n          = active_vertices();
        seen       = '0;
        got_parent = '0;
        depth      = 0;
        for (int k = 0; k < MAX_VERTICES; k++)
            parent_of[k] = '0;
        if (int'(start) < n) begin
            pending[0]        = start;
            depth             = 1;
            parent_of[start]  = start;
            got_parent[start] = 1'b1;
        end
        while (depth > 0) begin
            depth   = depth - 1;
            v       = int'(pending[depth]);
            seen[v] = 1'b1;
            for (int w = 0; w < n; w++) begin
                if (adj_rows[v][w] && !seen[w]) begin
                    parent_of[w]  = VIDX_W'(v);
                    got_parent[w] = 1'b1;
                    // a full stack drops the push, the parent stays written
                    if (depth < n) begin
                        pending[depth] = VIDX_W'(w);
                        depth          = depth + 1;
                    end
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            rep.vertex  = VIDX_W'(k);
            rep.parent  = got_parent[k] ? parent_of[k] : '0;
            rep.reached = got_parent[k];
            rep.last    = (k == n - 1);
            parent_reports_q.push_back(rep);
        end
    endfunction

    // offer one word, wait for it to be taken, then update the predictor
    task automatic send_word(input t_op op, input logic [VIDX_W-1:0] row,
                             input logic [MAX_VERTICES-1:0] bits,
                             input logic [VIDX_W-1:0] start, input logic typed,
                             input logic [MAX_VERTICES-1:0] exp_reached,
                             input logic [VIDX_W-1:0] exp_parent);
        t_result rep;
        int      n;
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'd0, start, bits, row};
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == OP_LOAD) begin
            adj_rows[row] = bits;
        end else if (typed) begin
            n = active_vertices();
            for (int k = 0; k < n; k++) begin
                rep.vertex  = VIDX_W'(k);
                rep.reached = exp_reached[k];
                rep.parent  = exp_reached[k] ? exp_parent : '0;
                rep.last    = (k == n - 1);
                parent_reports_q.push_back(rep);
            end
        end else begin
            predict_parent_tree(start);
        end
    endtask

    // stop offering, wait for every report, then let a load finish inside the block
    task automatic drain_reports();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (parent_reports_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_num_vertices(input logic [5:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        cfg_num_vertices = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // row contents: mostly sparse so searches run deep, sometimes empty or full
    function automatic logic [MAX_VERTICES-1:0] random_row_bits();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '1;
        if (pick == 1)
            return '0;
        if (pick <= 3)
            return $urandom();
        return $urandom() & $urandom() & $urandom();
    endfunction

    // receiver: random stalls, one long hold on request
    initial begin
        int hold_served;
        hold_served   = 0;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_ticket) begin
                hold_served = hold_ticket;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 9)) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // compare each report word against the oldest expectation
    always @(posedge i_clk) begin : check_reports
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (parent_reports_q.size() == 0) begin
                $error("unexpected report word: vertex %0d", m_axis_tdata[4:0]);
                err_count++;
            end else begin
                want = parent_reports_q.pop_front();
                if (m_axis_tdata[4:0] !== want.vertex) begin
                    $error("vertex mismatch: expected %0d, got %0d",
                           want.vertex, m_axis_tdata[4:0]);
                    err_count++;
                end
                if (m_axis_tdata[9:5] !== want.parent) begin
                    $error("parent mismatch: expected %0d, got %0d",
                           want.parent, m_axis_tdata[9:5]);
                    err_count++;
                end
                if (m_axis_tdata[10] !== want.reached) begin
                    $error("reached mismatch: expected %0d, got %0d",
                           want.reached, m_axis_tdata[10]);
                    err_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last mismatch: expected %0d, got %0d",
                           want.last, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        int         per_phase;
        int         n;
        logic [5:0] phase_sizes [NUM_PHASES];
        phase_sizes   = '{6'd32, 6'd3, 6'd1, 6'd63, 6'd8, 6'd0, 6'd2, 6'd17, 6'd40, 6'd5};
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_num_vertices = 6'd32;
        for (int k = 0; k < MAX_VERTICES; k++)
            adj_rows[k] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_table[i]) begin
            if (dir_table[i].kind == ENTRY_CFG) begin
                drain_reports();
                write_num_vertices(dir_table[i].cfg_value);
            end else begin
                send_word(dir_table[i].op, dir_table[i].row_index, dir_table[i].row_bits,
                          dir_table[i].start_vertex, dir_table[i].typed,
                          dir_table[i].exp_reached, dir_table[i].exp_parent);
            end
        end

        // fill every row so random searches never read an unloaded one
        drain_reports();
        write_num_vertices(6'd32);
        for (int r = 0; r < MAX_VERTICES; r++)
            send_word(OP_LOAD, VIDX_W'(r), random_row_bits(), VIDX_W'($urandom()),
                      1'b0, '0, '0);
        per_phase  = (RANDOM_WORDS - MAX_VERTICES) / NUM_PHASES;

        // random phases over several register settings, last one without idling
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_reports();
            if (p == NUM_PHASES - 1)
                quiet_mode = 1'b1;
            write_num_vertices(phase_sizes[p]);
            n = active_vertices();
            // long receiver hold while searches keep coming
            if (p == 1)
                hold_ticket++;
            for (int j = 0; j < per_phase; j++) begin
                if ($urandom_range(0, 9) < 3)
                    send_word(OP_LOAD, VIDX_W'($urandom()), random_row_bits(),
                              VIDX_W'($urandom()), 1'b0, '0, '0);
                else
                    send_word(OP_SEARCH, VIDX_W'($urandom()), $urandom(),
                              ($urandom_range(0, 9) < 8) ? VIDX_W'($urandom_range(0, n - 1))
                                                         : VIDX_W'($urandom()),
                              1'b0, '0, '0);
            end
        end

        drain_reports();
        repeat (20) @(posedge i_clk);
        if (err_count == 0 && parent_reports_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/dfs_pkg.sv
rtl/dfs_ram.sv
rtl/dfs_search.sv
rtl/dfs_parent_tree_adjacency_matrix.sv
sim/tb_dfs_parent_tree_adjacency_matrix.sv
